// ===== hw/rtl/bag_pkg.sv =====
// Shared types and constants for the bump allocator with guard pages.
package bag_pkg;

  localparam int unsigned AddrW   = 32;
  localparam int unsigned SizeW   = 25;
  localparam int unsigned ReqW    = 24;
  localparam int unsigned CountW  = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned PageW   = 12;
  localparam int unsigned CfgAddrW = 4;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned OutDataW = 128;

  localparam logic [SizeW-1:0] HEAP_BYTES_RESET = SizeW'(768 * 1024);

  // status codes
  localparam logic [StatusW-1:0] ST_GRANTED = 2'd0;
  localparam logic [StatusW-1:0] ST_NO_MEM  = 2'd1;
  localparam logic [StatusW-1:0] ST_FAULT   = 2'd2;
  localparam logic [StatusW-1:0] ST_HALTED  = 2'd3;

  // request kinds
  localparam logic FUNC_PLAIN   = 1'b0;
  localparam logic FUNC_GUARDED = 1'b1;

  // register indexes (byte address / 4)
  localparam logic [1:0] REG_HEAP_BASE   = 2'd0;
  localparam logic [1:0] REG_HEAP_BYTES  = 2'd1;
  localparam logic [1:0] REG_FAULT_AFTER = 2'd2;

  typedef struct packed {
    logic [SizeW-1:0]  used;
    logic [CountW-1:0] grants;
    logic [CountW-1:0] countdown;
    logic              halted;
  } bag_state_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [AddrW-1:0]   block_address;
    logic               guard_install;
    logic [AddrW-1:0]   guard_address;
  } bag_result_t;

endpackage

// ===== hw/rtl/bag_step.sv =====
// Next-state and result logic for one allocation request.
module bag_step (
  input  bag_pkg::bag_state_t        state_i,
  input  logic [bag_pkg::AddrW-1:0]  heap_base_i,
  input  logic [bag_pkg::SizeW-1:0]  heap_bytes_i,
  input  logic                       func_i,
  input  logic [bag_pkg::ReqW-1:0]   need_i,
  output bag_pkg::bag_state_t        state_o,
  output bag_pkg::bag_result_t       result_o
);
  import bag_pkg::*;

  logic [SizeW:0]   plain_sum;
  logic [SizeW:0]   plain_off;
  logic [SizeW+1:0] plain_end;
  logic             plain_fits;
  logic             injected;

  logic [PageW-1:0] cur_lo;
  logic [PageW-1:0] pad;
  logic [SizeW:0]   guard_off;
  logic [SizeW+1:0] usable_off;
  logic [SizeW+2:0] guard_end;
  logic             guard_fits;

  // plain: round used up to 8 bytes
  assign plain_sum  = {1'b0, state_i.used} + (SizeW+1)'(7);
  assign plain_off  = {plain_sum[SizeW:3], 3'b000};
  assign plain_end  = {1'b0, plain_off} + (SizeW+2)'(need_i);
  assign plain_fits = plain_end <= (SizeW+2)'(heap_bytes_i);
  assign injected   = state_i.countdown == CountW'(1);

  // guarded: distance from the absolute address up to the next page edge
  assign cur_lo     = heap_base_i[PageW-1:0] + state_i.used[PageW-1:0];
  assign pad        = PageW'(0) - cur_lo;
  assign guard_off  = {1'b0, state_i.used} + (SizeW+1)'(pad);
  assign usable_off = {1'b0, guard_off} + (SizeW+2)'(1 << PageW);
  assign guard_end  = {1'b0, usable_off} + (SizeW+3)'(need_i);
  assign guard_fits = guard_end <= (SizeW+3)'(heap_bytes_i);

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    if (state_i.halted) begin
      result_o.status = ST_HALTED;
    end else if (func_i == FUNC_PLAIN) begin
      if (state_i.countdown != '0) begin
        state_o.countdown = state_i.countdown - CountW'(1);
      end
      if (injected) begin
        result_o.status = ST_FAULT;
        state_o.halted  = 1'b1;
      end else if (!plain_fits) begin
        result_o.status = ST_NO_MEM;
        state_o.halted  = 1'b1;
      end else begin
        result_o.status        = ST_GRANTED;
        result_o.block_address = heap_base_i + AddrW'(plain_off);
        state_o.used           = plain_end[SizeW-1:0];
        state_o.grants         = state_i.grants + CountW'(1);
      end
    end else begin
      if (!guard_fits) begin
        result_o.status = ST_NO_MEM;
        state_o.halted  = 1'b1;
      end else begin
        result_o.status        = ST_GRANTED;
        result_o.guard_install = 1'b1;
        result_o.guard_address = heap_base_i + AddrW'(guard_off);
        result_o.block_address = heap_base_i + AddrW'(usable_off);
        state_o.used           = guard_end[SizeW-1:0];
        state_o.grants         = state_i.grants + CountW'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/bump_allocator_with_guard_pages_top.sv =====
// Top level of the bump allocator with guard pages: stream ports, registers, result stage.
//
//   channel | direction | beat contents
//   in_     | slave     | tuser: func; tdata: request_bytes
//   out_    | master    | tuser: status; tdata: block_address .. alloc_total
//   cfg_    | APB slave | heap_base @0x0, heap_bytes @0x4, fault_after @0x8
//
// One request per cycle unless a held result waits on out_tready; its result appears
// in the output register on the next cycle. The request is evaluated against the live
// state at acceptance, so back-to-back requests see each other's effect without bubbles.
// Sync active-low reset zeroes state, heap_base, fault_after, out valid; heap_bytes=768K.
// in_tready drops only while a result is held and out_tready is low.
module bump_allocator_with_guard_pages_top (
  input  logic                           clk,
  input  logic                           rst_n,
  // input stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [bag_pkg::ReqW-1:0]       in_tdata,   // [23:0] request_bytes
  input  logic [0:0]                     in_tuser,   // [0] func
  // result stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [31:0] block_address, [32] guard_install, [64:33] guard_address,
  // [89:65] heap_used, [121:90] alloc_total, [127:122] zero
  output logic [bag_pkg::OutDataW-1:0]   out_tdata,
  output logic [bag_pkg::StatusW-1:0]    out_tuser,  // [1:0] status
  // configuration
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [bag_pkg::CfgAddrW-1:0]   cfg_paddr,
  input  logic [bag_pkg::CfgDataW-1:0]   cfg_pwdata,
  output logic [bag_pkg::CfgDataW-1:0]   cfg_prdata,
  output logic                           cfg_pready
);
  import bag_pkg::*;

  logic [AddrW-1:0]  heap_base_r;
  logic [SizeW-1:0]  heap_bytes_r;
  logic [CountW-1:0] fault_after_r;
  bag_state_t        state_r;
  bag_state_t        state_nxt;
  bag_state_t        state_upd_nxt;
  bag_result_t       result_nxt;

  logic              out_valid_r;
  logic [OutDataW-1:0] out_data_r;
  logic [StatusW-1:0]  out_status_r;

  logic              in_fire;
  logic              cfg_wr;
  logic [1:0]        cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[3:2];

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  bag_step u_step (
    .state_i      (state_r),
    .heap_base_i  (heap_base_r),
    .heap_bytes_i (heap_bytes_r),
    .func_i       (in_tuser[0]),
    .need_i       (in_tdata),
    .state_o      (state_nxt),
    .result_o     (result_nxt)
  );

  always_comb begin
    unique case (cfg_idx)
      REG_HEAP_BASE:   cfg_prdata = heap_base_r;
      REG_HEAP_BYTES:  cfg_prdata = CfgDataW'(heap_bytes_r);
      REG_FAULT_AFTER: cfg_prdata = fault_after_r;
      default:         cfg_prdata = '0;
    endcase
  end

  // a fault_after write reloads the countdown
  always_comb begin
    state_upd_nxt = in_fire ? state_nxt : state_r;
    if (cfg_wr && cfg_idx == REG_FAULT_AFTER) begin
      state_upd_nxt.countdown = cfg_pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_base_r   <= '0;
      heap_bytes_r  <= HEAP_BYTES_RESET;
      fault_after_r <= '0;
      state_r       <= '0;
    end else begin
      state_r <= state_upd_nxt;
      if (cfg_wr) begin
        unique case (cfg_idx)
          REG_HEAP_BASE:   heap_base_r   <= cfg_pwdata;
          REG_HEAP_BYTES:  heap_bytes_r  <= cfg_pwdata[SizeW-1:0];
          REG_FAULT_AFTER: fault_after_r <= cfg_pwdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_status_r <= result_nxt.status;
      out_data_r   <= {6'b0, state_nxt.grants, state_nxt.used,
                       result_nxt.guard_address, result_nxt.guard_install,
                       result_nxt.block_address};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

endmodule
